/* hw/rtl/fcd_pkg.sv */
package fcd_pkg;

  // Filter geometry.
  localparam int unsigned TAPS       = 8;
  localparam int unsigned DECIMATION = 4;
  localparam int unsigned OUT_SHIFT  = 11;

  // Field and datapath widths.
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned COEF_W   = 8;
  localparam int unsigned PROD_W   = SAMPLE_W + COEF_W;
  localparam int unsigned ACC_W    = 19;
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned TAP_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned PHASE_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

  // Configuration register indices.
  localparam logic [CFG_IDX_W-1:0] CFG_COEFFS_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COEFFS_SECOND = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN1,
    ST_RUN2,
    ST_HOLD
  } fcd_state_e;

endpackage

/* hw/rtl/fcd_in_if.sv */
interface fcd_in_if
  import fcd_pkg::*;
();

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);

endinterface

/* hw/rtl/fcd_out_if.sv */
interface fcd_out_if
  import fcd_pkg::*;
();

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);

endinterface

/* hw/rtl/fir_cascade_decimate_by_four_top.sv */
// Two cascaded 8-tap FIR filters followed by a keep-one-in-four decimator.
//
// Samples arrive as requests on in_i (valid/ready); every fourth filtered
// sample, starting with the first after reset, leaves as a request on out_o.
// The coefficient sets are written through cfg_we_i, cfg_idx_i and cfg_data_i:
// index 0 holds the first-stage taps, index 1 the second-stage taps, tap 0 in
// the lowest byte. Writes to any other index are ignored. Coefficients should
// only be changed while the block is idle.
//
// A single signed 8x8 multiplier with a 19-bit accumulator serves both
// filters, one tap per cycle. An accepted request therefore runs through all
// taps of the first stage and then all taps of the second, and only then does
// the block return to idle and take a new sample. At the last second-stage tap
// the result is registered at the output, if the output register is free.
//
// The output register lets the next sample be accepted while a result still
// waits. If the receiver is still stalling when the following result is
// ready, the sequencer holds that result and stays busy until out_o is free.
// Reset clears both delay lines, the decimation phase, the coefficients and
// the output valid flag.
module fir_cascade_decimate_by_four_top
  import fcd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  fcd_in_if.sink                in_i,
  fcd_out_if.source             out_o
);

  localparam logic [TAP_W-1:0]   LAST_TAP   = TAP_W'(TAPS - 1);
  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(DECIMATION - 1);

  fcd_state_e state_q, state_d;

  logic [CFG_W-1:0] coeffs_first_q, coeffs_second_q;

  logic signed [SAMPLE_W-1:0] line1_q [TAPS];
  logic signed [SAMPLE_W-1:0] line2_q [TAPS];

  logic [TAP_W-1:0]   tap_q;
  logic [PHASE_W-1:0] phase_q;
  logic               emit_q;

  logic signed [ACC_W-1:0]    acc_q;
  logic signed [SAMPLE_W-1:0] res_q;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_data_q;

  // Sequencer outputs.
  logic                       in_ready;
  logic                       in_accept;
  logic                       out_free;
  logic                       last_tap;
  logic                       out_load;
  logic signed [SAMPLE_W-1:0] out_data_d;

  // Shared multiply-accumulate unit.
  logic signed [COEF_W-1:0]   coef_sel;
  logic signed [SAMPLE_W-1:0] data_sel;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    mac_sum;
  logic signed [ACC_W-1:0]    mac_shifted;
  logic signed [SAMPLE_W-1:0] stage_out;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeffs_first_q  <= '0;
      coeffs_second_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COEFFS_FIRST:  coeffs_first_q  <= cfg_data_i;
        CFG_COEFFS_SECOND: coeffs_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The MAC reads the tap selected by the counter from whichever stage runs.
  always_comb begin
    if (state_q == ST_RUN2) begin
      coef_sel = coeffs_second_q[tap_q*COEF_W +: COEF_W];
      data_sel = line2_q[tap_q];
    end else begin
      coef_sel = coeffs_first_q[tap_q*COEF_W +: COEF_W];
      data_sel = line1_q[tap_q];
    end
  end

  assign prod        = coef_sel * data_sel;
  assign mac_sum     = acc_q + ACC_W'(prod);
  assign mac_shifted = mac_sum >>> OUT_SHIFT;
  // The stage result wraps to the low byte rather than saturating.
  assign stage_out   = mac_shifted[SAMPLE_W-1:0];

  assign in_accept = in_i.valid && in_ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign last_tap  = (tap_q == LAST_TAP);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_RUN1;
        end
      end
      ST_RUN1: begin
        if (last_tap) begin
          state_d = ST_RUN2;
        end
      end
      ST_RUN2: begin
        if (last_tap) begin
          state_d = (emit_q && !out_free) ? ST_HOLD : ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready   = 1'b0;
    out_load   = 1'b0;
    out_data_d = stage_out;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_RUN1: ;
      ST_RUN2: begin
        out_load = last_tap && emit_q && out_free;
      end
      ST_HOLD: begin
        out_load   = out_free;
        out_data_d = res_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_q   <= '0;
      phase_q <= '0;
      emit_q  <= 1'b0;
      acc_q   <= '0;
      for (int i = 0; i < TAPS; i++) begin
        line1_q[i] <= '0;
        line2_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (in_accept) begin
        // Newest sample goes in at tap 0; the decimation phase moves on.
        line1_q[0] <= in_i.sample_in;
        for (int i = 1; i < TAPS; i++) begin
          line1_q[i] <= line1_q[i-1];
        end
        emit_q  <= (phase_q == '0);
        phase_q <= (phase_q == LAST_PHASE) ? '0 : phase_q + PHASE_W'(1);
        acc_q   <= '0;
        tap_q   <= '0;
      end

      if (state_q == ST_RUN1 || state_q == ST_RUN2) begin
        tap_q <= last_tap ? '0 : tap_q + TAP_W'(1);
        // The accumulator starts afresh for the second stage.
        acc_q <= (state_q == ST_RUN1 && last_tap) ? '0 : mac_sum;
      end

      if (state_q == ST_RUN1 && last_tap) begin
        // The first-stage result enters the second delay line.
        line2_q[0] <= stage_out;
        for (int i = 1; i < TAPS; i++) begin
          line2_q[i] <= line2_q[i-1];
        end
      end
    end
  end

  // Kept in case the output register is still occupied when stage two ends.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RUN2 && last_tap) begin
      res_q <= stage_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

  // An accepted sample always starts the first stage at tap 0.
  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_RUN1 && tap_q == '0))
    else $error("accepted sample did not start the first stage");

  // Only the first sample of each decimation group produces a result.
  a_load_only_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> emit_q)
    else $error("result loaded for a decimated sample");

  // Holding a result only makes sense while the output register is occupied.
  a_hold_needs_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD) |-> out_valid_q)
    else $error("holding a result with an empty output register");

  // The decimation phase moves only when a sample is accepted.
  a_phase_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(phase_q))
    else $error("decimation phase changed without an accepted sample");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
  import fcd_pkg::*;
();

  // Register indices that the block does not decode; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = CFG_IDX_W'(3);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 8'sd127;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -8'sd128;

  localparam logic [CFG_W-1:0] COEFS_ALL_MAX = {TAPS{8'h7F}};
  localparam logic [CFG_W-1:0] COEFS_ALL_MIN = {TAPS{8'h80}};
  localparam logic [CFG_W-1:0] COEFS_MIXED   = {(TAPS / 2){8'h80, 8'h7F}};

  // The drain wait leaves a comfortable margin for a sample that produces no result
  // to finish inside the block before the coefficients change.
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 400_000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  fcd_in_if  in_bus ();
  fcd_out_if out_bus ();

  fir_cascade_decimate_by_four_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  always #5 clk_i = ~clk_i;

  // Samples waiting to be offered, and the decimated outputs that the model
  // of the cascade says must come back, oldest first.
  logic signed [SAMPLE_W-1:0] samples_to_send [$];
  logic signed [SAMPLE_W-1:0] decimated_expect [$];

  // Our own copy of the filter state and of the coefficient registers.
  logic signed [SAMPLE_W-1:0] first_taps  [TAPS];
  logic signed [SAMPLE_W-1:0] second_taps [TAPS];
  logic [PHASE_W-1:0]         decim_phase;
  logic [CFG_W-1:0]           coefs_first;
  logic [CFG_W-1:0]           coefs_second;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off;
  bit          req_taken;
  int unsigned pushed_total;
  int unsigned accepted_total;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  // Multiply-accumulate over one delay line. The sum is kept in an accumulator
  // as wide as the block's, shifted arithmetically and narrowed by wrapping to
  // the low byte, never by saturation.
  function automatic logic signed [SAMPLE_W-1:0] tap_sum(
    input logic signed [SAMPLE_W-1:0] taps [TAPS],
    input logic [CFG_W-1:0]           coefs
  );
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  shifted;
    logic signed [COEF_W-1:0] coef;
    logic signed [PROD_W-1:0] prod;
    acc = '0;
    for (int i = 0; i < TAPS; i++) begin
      coef = coefs[COEF_W*i +: COEF_W];
      prod = coef * taps[i];
      acc  = acc + prod;
    end
    shifted = acc >>> OUT_SHIFT;
    return shifted[SAMPLE_W-1:0];
  endfunction

  // Runs one accepted sample through both stages and keeps the first output
  // of every group of DECIMATION.
  task automatic advance_cascade(input logic signed [SAMPLE_W-1:0] sample);
    logic signed [SAMPLE_W-1:0] mid;
    logic signed [SAMPLE_W-1:0] fin;
    for (int i = TAPS - 1; i > 0; i--) first_taps[i] = first_taps[i-1];
    first_taps[0] = sample;
    mid = tap_sum(first_taps, coefs_first);
    for (int i = TAPS - 1; i > 0; i--) second_taps[i] = second_taps[i-1];
    second_taps[0] = mid;
    fin = tap_sum(second_taps, coefs_second);
    if (decim_phase == '0) decimated_expect.push_back(fin);
    decim_phase = PHASE_W'((decim_phase + 1) % DECIMATION);
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // The free-running cycle counter doubles as the watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Monitor: at each rising edge it first checks any output request against the
  // oldest expectation and then feeds an accepted input request to the model.
  // A result leaves only after both filter stages have run, so the order of the two is safe.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_taken = 1'b0;
    end else begin
      req_taken = in_bus.valid && in_bus.ready;
      if (out_bus.valid && out_bus.ready) begin
        if (decimated_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected output %0d", out_bus.sample_out));
        end else begin
          logic signed [SAMPLE_W-1:0] want;
          want = decimated_expect.pop_front();
          if (out_bus.sample_out !== want) begin
            report_mismatch($sformatf("sample_out %0d, expected %0d",
                                      out_bus.sample_out, want));
          end
        end
      end
      if (req_taken) begin
        accepted_total++;
        advance_cascade(in_bus.sample_in);
      end
    end
  end

  // Driver: a request that has not yet been taken is held steady. Otherwise the
  // next sample is offered unless the sender idles this cycle or the stimulus
  // has asked it to hold off.
  always @(negedge clk_i) begin
    if (in_bus.valid && !req_taken) begin
      // Request still pending; leave it as it is.
    end else if (samples_to_send.size() > 0 && !hold_off &&
                 $urandom_range(99) >= send_idle_pct) begin
      in_bus.valid     <= 1'b1;
      in_bus.sample_in <= samples_to_send.pop_front();
    end else begin
      in_bus.valid <= 1'b0;
    end
  end

  // The receiver stalls at random, at the rate the current phase asks for.
  always @(negedge clk_i) begin
    out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // The stimulus process works one nanosecond after the rising edge, clear of
  // both the sampling edge and the driving edge.
  task automatic next_cycle();
    @(posedge clk_i);
    #1;
  endtask

  task automatic queue_sample(input logic signed [SAMPLE_W-1:0] sample);
    samples_to_send.push_back(sample);
    pushed_total++;
  endtask

  // Random samples. Half the draws are runs of one level, slightly jittered,
  // so that the first stage produces large outputs and the second stage sees
  // more than a trickle of small values; the rest are uniform noise.
  task automatic queue_random_samples(input int unsigned count);
    int unsigned left;
    int unsigned run;
    logic signed [SAMPLE_W-1:0] level;
    left = count;
    while (left > 0) begin
      if ($urandom_range(1) == 0) begin
        case ($urandom_range(3))
          0:       level = SAMPLE_MAX;
          1:       level = SAMPLE_MIN;
          default: level = SAMPLE_W'($urandom);
        endcase
        run = $urandom_range(12, 3);
        if (run > left) run = left;
        repeat (run) queue_sample(level ^ SAMPLE_W'($urandom_range(3)));
        left -= run;
      end else begin
        queue_sample(SAMPLE_W'($urandom));
        left--;
      end
    end
  endtask

  // Coefficients change only while the block is idle, so the model can take the
  // new value at once.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_COEFFS_FIRST:  coefs_first  = data;
      CFG_COEFFS_SECOND: coefs_second = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_coefficients(input logic [CFG_W-1:0] first,
                                   input logic [CFG_W-1:0] second);
    write_register(CFG_COEFFS_FIRST, first);
    write_register(CFG_COEFFS_SECOND, second);
  endtask

  // Waits until every sample has been taken and every result has come back,
  // then gives a sample that produces no result time to leave the datapath.
  task automatic wait_until_idle();
    while (accepted_total != pushed_total || decimated_expect.size() != 0) next_cycle();
    repeat (DRAIN_CYCLES) next_cycle();
  endtask

  initial begin
    in_bus.valid     = 1'b0;
    in_bus.sample_in = '0;
    out_bus.ready    = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    rst_ni           = 1'b0;
    hold_off         = 1'b0;
    send_idle_pct    = 14;
    recv_idle_pct    = 69;
    coefs_first      = '0;
    coefs_second     = '0;
    decim_phase      = '0;
    for (int i = 0; i < TAPS; i++) begin
      first_taps[i]  = '0;
      second_taps[i] = '0;
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    next_cycle();

    // Directed part with the largest positive taps: a full line of the most
    // positive sample, then of the most negative, then single extremes and
    // bit patterns, so that the first-stage sum reaches its extremes for these taps.
    load_coefficients(COEFS_ALL_MAX, COEFS_ALL_MAX);
    repeat (TAPS) queue_sample(SAMPLE_MAX);
    repeat (TAPS) queue_sample(SAMPLE_MIN);
    queue_sample('0);
    queue_sample(-8'sd1);
    queue_sample(8'sd1);
    queue_sample(SAMPLE_MAX);
    queue_sample(SAMPLE_MIN);
    queue_sample(8'sh55);
    queue_sample(-8'sh56);
    queue_sample('0);
    wait_until_idle();

    // Writes to the undecoded indices must leave both coefficient sets alone;
    // the most negative taps with runs of extremes drive the largest sums.
    write_register(CFG_IDX_SPARE_LO, {$urandom, $urandom});
    write_register(CFG_IDX_SPARE_HI, {$urandom, $urandom});
    write_register(CFG_COEFFS_FIRST, COEFS_ALL_MIN);
    write_register(CFG_IDX_SPARE_LO, {$urandom, $urandom});
    write_register(CFG_COEFFS_SECOND, COEFS_ALL_MIN);
    queue_random_samples(250);
    wait_until_idle();

    load_coefficients({$urandom, $urandom}, {$urandom, $urandom});
    queue_random_samples(250);
    wait_until_idle();

    // Now the sender is the slow side. Part way through, it stops offering
    // requests until the block has returned everything it owes.
    send_idle_pct = 69;
    recv_idle_pct = 14;
    load_coefficients(COEFS_MIXED, {$urandom, $urandom});
    queue_random_samples(130);
    while (accepted_total + 60 > pushed_total) next_cycle();
    hold_off = 1'b1;
    while (decimated_expect.size() != 0) next_cycle();
    hold_off = 1'b0;
    queue_random_samples(130);
    wait_until_idle();

    // All-zero taps: everything that comes out must be zero.
    load_coefficients('0, '0);
    queue_random_samples(150);
    wait_until_idle();

    // Finally neither side idles, so requests arrive back to back.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_coefficients({$urandom, $urandom}, COEFS_ALL_MAX);
    queue_random_samples(250);
    wait_until_idle();

    load_coefficients({$urandom, $urandom}, {$urandom, $urandom});
    queue_random_samples(300);
    wait_until_idle();

    if (decimated_expect.size() != 0) begin
      report_mismatch($sformatf("%0d outputs never arrived", decimated_expect.size()));
    end

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/fcd_pkg.sv
hw/rtl/fcd_in_if.sv
hw/rtl/fcd_out_if.sv
hw/rtl/fir_cascade_decimate_by_four_top.sv
test/tb_top.sv
